[rtl/core/dct_pkg.sv]
// Shared types, constants and the reset basis table of the 8x8 forward DCT.
package dct_pkg;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SCAN_A, ST_SCAN_B, ST_SCAN_C, ST_RD, ST_RDB, ST_ACC, ST_STORE
  } dct_state_t;

  localparam logic [1:0] MODE_EXACT = 2'd0;
  localparam logic [1:0] MODE_FAST  = 2'd1;
  localparam logic [1:0] MODE_SYM   = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_BASIS  = 1'b1;

  localparam int unsigned QBITS = 14;
  localparam logic signed [31:0] QHALF    = 32'sh0000_2000;
  localparam logic signed [32:0] HMUL_RND = 33'sh0_0000_4000;
  localparam logic signed [15:0] SAT_MAX  = 16'sh7FFF;
  localparam logic signed [15:0] SAT_MIN  = -16'sh7FFF - 16'sh0001;

  // Half-cosine magnitudes in Q14, indexed by angle in sixteenths of pi.
  localparam logic signed [15:0] COS_HALF [0:8] = '{
    16'sd8192, 16'sd8035, 16'sd7568, 16'sd6811, 16'sd5793,
    16'sd4551, 16'sd3135, 16'sd1598, 16'sd0
  };

  typedef struct packed {
    logic        smp_we;
    logic [5:0]  smp_addr;
    logic        bas_we;
    logic        src_re;
    logic        src_pass;
    logic [5:0]  src_addr;
    logic        bas_re;
    logic [5:0]  bas_addr;
    logic        latch_a;
    logic        acc_clr;
    logic        acc_step;
    logic        odd_row;
    logic [1:0]  mode;
    logic        scan_latch;
    logic        scan_cmp;
    logic        scan_odd;
    logic        fault_clr;
    logic        pass_we;
    logic [5:0]  dst_addr;
    logic        out_load;
    logic        out_last;
  } dct_cmd_t;

  typedef struct packed {
    logic out_free;
  } dct_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
    logic signed [15:0] r;
    if (v > 34'(SAT_MAX)) r = SAT_MAX;
    else if (v < 34'(SAT_MIN)) r = SAT_MIN;
    else r = v[15:0];
    return r;
  endfunction

  // Reset basis entry for position row*8+column.
  function automatic logic signed [15:0] basis_reset(input logic [5:0] n);
    logic [6:0] ang;
    logic [4:0] m;
    logic [4:0] f;
    logic signed [15:0] r;
    ang = 7'({n[2:0], 1'b1}) * 7'(n[5:3]);
    m = ang[4:0];
    f = (m > 5'd16) ? (5'd0 - m) : m;
    if (f > 5'd8) r = -COS_HALF[4'(5'd16 - f)];
    else r = COS_HALF[4'(f)];
    return r;
  endfunction

endpackage

[rtl/core/dct_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dct_ram #(
  parameter int W = 16,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem_r [0:D-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end
endmodule

[rtl/core/dct_ctrl.sv]
// Sequencer of the DCT: block loading, basis symmetry scan and both passes.
module dct_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_wdata,
  input  dct_pkg::dct_status_t stat,
  output dct_pkg::dct_cmd_t    cmd
);
  import dct_pkg::*;

  dct_state_t state_r, state_nxt;
  logic [2:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic       pass_r, pass_nxt;
  logic [4:0] scan_r, scan_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] mode_r;
  logic       sym;
  logic       smp_xfer;

  assign sym = (mode_r == MODE_SYM);
  assign in_tready = (state_r == ST_LOAD);
  assign smp_xfer = in_tvalid && (in_tuser == KIND_SAMPLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      i_r <= '0; j_r <= '0; k_r <= '0;
      pass_r <= 1'b0; scan_r <= '0; cnt_r <= '0;
      mode_r <= MODE_EXACT;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt; j_r <= j_nxt; k_r <= k_nxt;
      pass_r <= pass_nxt; scan_r <= scan_nxt; cnt_r <= cnt_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    pass_nxt = pass_r; scan_nxt = scan_r; cnt_nxt = cnt_r;
    case (state_r)
      ST_LOAD: begin
        if (smp_xfer) begin
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd63) begin
            pass_nxt = 1'b0;
            i_nxt = '0; j_nxt = '0; k_nxt = '0; scan_nxt = '0;
            state_nxt = sym ? ST_SCAN_A : ST_RD;
          end
        end
      end
      ST_SCAN_A: state_nxt = ST_SCAN_B;
      ST_SCAN_B: state_nxt = ST_SCAN_C;
      ST_SCAN_C: begin
        scan_nxt = scan_r + 5'd1;
        state_nxt = (scan_r == 5'd31) ? ST_RD : ST_SCAN_A;
      end
      ST_RD:  state_nxt = sym ? ST_RDB : ST_ACC;
      ST_RDB: state_nxt = ST_ACC;
      ST_ACC: begin
        if ((sym && k_r == 3'd3) || k_r == 3'd7) begin
          k_nxt = '0;
          state_nxt = ST_STORE;
        end else begin
          k_nxt = k_r + 3'd1;
          state_nxt = ST_RD;
        end
      end
      ST_STORE: begin
        if (!pass_r || stat.out_free) begin
          j_nxt = j_r + 3'd1;
          state_nxt = ST_RD;
          if (j_r == 3'd7) begin
            i_nxt = i_r + 3'd1;
            if (i_r == 3'd7) begin
              pass_nxt = 1'b1;
              if (pass_r) begin
                state_nxt = ST_LOAD;
              end
            end
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mode = mode_r;
    cmd.odd_row = i_r[0];
    cmd.src_pass = pass_r;
    cmd.smp_addr = cnt_r;
    cmd.dst_addr = {i_r, j_r};
    cmd.out_last = (i_r == 3'd7) && (j_r == 3'd7);
    cmd.scan_odd = scan_r[2];
    case (state_r)
      ST_LOAD: begin
        cmd.smp_we = smp_xfer;
        cmd.bas_we = in_tvalid && (in_tuser == KIND_BASIS);
        cmd.fault_clr = smp_xfer && (cnt_r == 6'd63);
      end
      ST_SCAN_A: begin
        cmd.bas_re = 1'b1;
        cmd.bas_addr = {scan_r[4:2], 1'b0, scan_r[1:0]};
      end
      ST_SCAN_B: begin
        cmd.scan_latch = 1'b1;
        cmd.bas_re = 1'b1;
        cmd.bas_addr = {scan_r[4:2], 1'b1, ~scan_r[1:0]};
      end
      ST_SCAN_C: cmd.scan_cmp = 1'b1;
      ST_RD: begin
        cmd.src_re = 1'b1;
        cmd.src_addr = {j_r, k_r};
        cmd.bas_re = 1'b1;
        cmd.bas_addr = {i_r, k_r};
        cmd.acc_clr = (k_r == 3'd0);
      end
      ST_RDB: begin
        cmd.latch_a = 1'b1;
        cmd.src_re = 1'b1;
        cmd.src_addr = {j_r, ~k_r};
      end
      ST_ACC: cmd.acc_step = 1'b1;
      ST_STORE: begin
        cmd.pass_we = !pass_r;
        cmd.out_load = pass_r && stat.out_free;
      end
      default: ;
    endcase
  end
endmodule

[rtl/core/dct_dp.sv]
// Datapath of the DCT: stores, shared multiply-accumulate and output register.
module dct_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [39:0]        in_tdata,
  input  dct_pkg::dct_cmd_t  cmd,
  output dct_pkg::dct_status_t stat,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);
  import dct_pkg::*;

  logic [15:0] smp_q, pass_q, bas_raw;
  logic [63:0] bvalid_r;
  logic [5:0]  bas_raddr_r;
  logic signed [15:0] bq, src_q, a_r, scan_a_r;
  logic signed [31:0] acc_r, acc_nxt;
  logic        fault_r;
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_last_r, out_fault_r;
  logic signed [15:0] res;

  logic               exact;
  logic signed [15:0] a_s, x16, q16, mul_a, mul_b, h16;
  logic signed [31:0] prod;
  logic signed [32:0] rnd;
  logic signed [31:0] fin;
  logic signed [16:0] neg_a;

  dct_ram #(.W(16), .D(64)) u_smp (
    .clk(clk), .we(cmd.smp_we), .waddr(cmd.smp_addr), .wdata(in_tdata[15:0]),
    .re(cmd.src_re && !cmd.src_pass), .raddr(cmd.src_addr), .rdata(smp_q)
  );

  dct_ram #(.W(16), .D(64)) u_pass (
    .clk(clk), .we(cmd.pass_we), .waddr(cmd.dst_addr), .wdata(res),
    .re(cmd.src_re && cmd.src_pass), .raddr(cmd.src_addr), .rdata(pass_q)
  );

  dct_ram #(.W(16), .D(64)) u_bas (
    .clk(clk), .we(cmd.bas_we), .waddr(in_tdata[21:16]), .wdata(in_tdata[37:22]),
    .re(cmd.bas_re), .raddr(cmd.bas_addr), .rdata(bas_raw)
  );

  // An entry never written reads as the standard cosine table.
  assign bq = bvalid_r[bas_raddr_r] ? bas_raw : basis_reset(bas_raddr_r);
  assign src_q = cmd.src_pass ? pass_q : smp_q;

  assign exact = (cmd.mode != MODE_FAST) && (cmd.mode != MODE_SYM);
  assign a_s = (cmd.mode == MODE_SYM) ? a_r : src_q;

  always_comb begin
    if (cmd.odd_row) x16 = sat16(34'(a_s) - 34'(src_q));
    else x16 = sat16(34'(a_s) + 34'(src_q));
    q16 = sat16(34'(bq) <<< 1);
    mul_a = exact ? a_s : ((cmd.mode == MODE_SYM) ? x16 : a_s);
    mul_b = exact ? bq : q16;
    prod = mul_a * mul_b;
    rnd = 33'(prod) + HMUL_RND;
    h16 = rnd[30:15];
    if (exact) acc_nxt = acc_r + prod;
    else acc_nxt = 32'(sat16(34'($signed(acc_r[15:0])) + 34'(h16)));
    fin = (acc_r + QHALF) >>> QBITS;
    res = exact ? sat16(34'(fin)) : acc_r[15:0];
    neg_a = -17'(scan_a_r);
  end

  assign stat.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= '0;
      out_valid_r <= 1'b0;
      fault_r <= 1'b0;
    end else begin
      if (cmd.bas_we) begin
        bvalid_r[in_tdata[21:16]] <= 1'b1;
      end
      if (cmd.fault_clr) begin
        fault_r <= 1'b0;
      end else if (cmd.scan_cmp) begin
        if (cmd.scan_odd ? (17'(bq) != neg_a) : (bq != scan_a_r)) begin
          fault_r <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.bas_re) begin
      bas_raddr_r <= cmd.bas_addr;
    end
    if (cmd.latch_a) begin
      a_r <= src_q;
    end
    if (cmd.scan_latch) begin
      scan_a_r <= bq;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_step) begin
      acc_r <= acc_nxt;
    end
    if (cmd.out_load) begin
      out_data_r <= res;
      out_last_r <= cmd.out_last;
      out_fault_r <= fault_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;
  assign out_tuser = out_fault_r;
endmodule

[rtl/core/dct8x8_forward_multimode.sv]
// Top level of the two-pass 8x8 forward DCT with exact, fast and symmetric modes.
//
// Channel  Direction  Contents
// in_      slave      tuser: kind; tdata: sample, basis_index, basis_value
// out_     master     tdata: coefficient; tlast: last_coefficient; tuser: basis_fault
// cfg_     write      transform_mode
//
// Samples and basis words are taken one a cycle while loading. The 64th sample
// starts the transform: two passes of 64 coefficients through one shared
// multiply-accumulate, eight terms each in exact and fast modes and four in
// symmetric mode, which first scans the basis for mirror symmetry.
// A stalled output holds the second pass; no input is taken until the last
// coefficient has entered the output register.
// Reset restores the standard basis and mode zero; it needs no clearing pass.
module dct8x8_forward_multimode (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // sample, basis_index, basis_value
  input  logic        in_tuser,   // kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // coefficient
  output logic        out_tlast,  // last_coefficient
  output logic        out_tuser,  // basis_fault
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata   // transform_mode
);
  import dct_pkg::*;

  dct_cmd_t    cmd;
  dct_status_t stat;

  dct_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .stat(stat), .cmd(cmd)
  );

  dct_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_tdata(in_tdata), .cmd(cmd), .stat(stat),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );
endmodule

[tb/dct8x8_forward_multimode_tb.sv]
// Self-checking testbench for the multimode 8x8 forward DCT, with its own bit-true predictor.
`timescale 1ns / 100ps

module dct8x8_forward_multimode_tb;
  import dct_pkg::*;

  typedef shortint blk_t [64];

  typedef struct {
    shortint coef;
    bit      last;
    bit      fault;
  } coef_t;

  typedef struct {
    bit       kind;
    bit [5:0] idx;
    shortint  bval;
    shortint  smp;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // sample, basis_index, basis_value
  logic        in_tuser;   // kind
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // coefficient
  logic        out_tlast;  // last_coefficient
  logic        out_tuser;  // basis_fault
  logic        cfg_we;
  logic [1:0]  cfg_wdata;  // transform_mode

  // Predictor state.
  blk_t       basis_q14;
  blk_t       samples;
  blk_t       stage;
  int         fill;
  logic [1:0] cur_mode;
  coef_t      coef_queue[$];

  int  errors;
  int  rx_count;
  bit  tx_quiet;
  bit  rx_held;

  dct8x8_forward_multimode dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic shortint clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return -16'sh7FFF - 16'sh0001;
    return shortint'(v);
  endfunction

  // Rounded high half of a 16x16 product; only -32768 squared wraps.
  function automatic shortint mul_q15(shortint a, shortint b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd16384;
    return shortint'(p >>> 15);
  endfunction

  function automatic void pass_exact(input blk_t src, output blk_t dst);
    longint sum;
    int     acc;
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++) begin
        sum = 0;
        for (int k = 0; k < 8; k++)
          sum += longint'(src[8*j+k]) * longint'(basis_q14[8*i+k]);
        acc = int'(sum) + 32'sh2000;
        dst[8*i+j] = clamp16(longint'(acc >>> 14));
      end
  endfunction

  function automatic void pass_fast(input blk_t src, input blk_t q15, output blk_t dst);
    shortint acc;
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++) begin
        acc = 0;
        for (int k = 0; k < 8; k++)
          acc = clamp16(longint'(acc) + mul_q15(src[8*j+k], q15[8*i+k]));
        dst[8*i+j] = acc;
      end
  endfunction

  function automatic void pass_sym(input blk_t src, input blk_t q15, output blk_t dst);
    shortint ev[4];
    shortint od[4];
    shortint acc;
    shortint a;
    shortint b;
    for (int j = 0; j < 8; j++) begin
      for (int k = 0; k < 4; k++) begin
        a = src[8*j+k];
        b = src[8*j+7-k];
        ev[k] = clamp16(longint'(a) + b);
        od[k] = clamp16(longint'(a) - b);
      end
      for (int i = 0; i < 8; i++) begin
        acc = 0;
        for (int k = 0; k < 4; k++)
          acc = clamp16(longint'(acc) + mul_q15((i % 2) ? od[k] : ev[k], q15[8*i+k]));
        dst[8*i+j] = acc;
      end
    end
  endfunction

  function automatic bit basis_is_mirrored();
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 4; c++)
        if (int'(basis_q14[8*r+7-c]) != ((r % 2) ? -int'(basis_q14[8*r+c])
                                                  : int'(basis_q14[8*r+c])))
          return 1'b0;
    return 1'b1;
  endfunction

  // Applies one accepted input transfer and queues the coefficients it completes.
  function automatic void predict_transfer(bit kind, bit [5:0] idx, shortint bval,
                                           shortint smp);
    blk_t  q15;
    blk_t  coefs;
    bit    fault;
    coef_t c;
    if (kind == KIND_BASIS) begin
      basis_q14[idx] = bval;
      return;
    end
    samples[fill] = smp;
    fill = (fill + 1) % 64;
    if (fill != 0) return;
    for (int n = 0; n < 64; n++) q15[n] = clamp16(2 * longint'(basis_q14[n]));
    fault = 1'b0;
    if (cur_mode == MODE_FAST) begin
      pass_fast(samples, q15, stage);
      pass_fast(stage, q15, coefs);
    end else if (cur_mode == MODE_SYM) begin
      fault = !basis_is_mirrored();
      pass_sym(samples, q15, stage);
      pass_sym(stage, q15, coefs);
    end else begin
      pass_exact(samples, stage);
      pass_exact(stage, coefs);
    end
    samples = coefs;
    for (int n = 0; n < 64; n++) begin
      c.coef  = coefs[n];
      c.last  = (n == 63);
      c.fault = fault;
      coef_queue.insert(coef_queue.size(), c);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on coefficient %0d: %s got %0d, expected %0d", rx_count, what, got, want);
    errors++;
  endtask

  task automatic send(bit kind, bit [5:0] idx, shortint bval, shortint smp);
    if (!tx_quiet && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tuser  <= kind;
    in_tdata  <= {2'b00, bval, idx, smp};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_transfer(kind, idx, bval, smp);
  endtask

  // Mode changes only between blocks, once every coefficient is out.
  // With the mode unchanged the next block follows straight on.
  task automatic set_mode(logic [1:0] m);
    if (m == cur_mode) return;
    in_tvalid <= 1'b0;
    wait (coef_queue.size() == 0);
    repeat (40) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cur_mode = m;
    cfg_we   <= 1'b0;
  endtask

  // Writes mirror entries so that the basis passes the symmetry test.
  task automatic mirror_basis();
    shortint v;
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 4; c++) begin
        v = basis_q14[8*r+c];
        if (r % 2 == 1 && v == -16'sh8000) begin
          v = -16'sh7FFF;
          send(KIND_BASIS, 6'(8*r+c), v, 16'sh0);
        end
        if (basis_q14[8*r+7-c] != ((r % 2) ? -v : v))
          send(KIND_BASIS, 6'(8*r+7-c), (r % 2) ? -v : v, 16'sh0);
      end
  endtask

  function automatic shortint pick_sample(int style);
    case (style)
      0: return shortint'($urandom);
      1: return shortint'($urandom_range(1023)) - 16'sd512;
      default: begin
        case ($urandom_range(3))
          0: return 16'sh7FFF;
          1: return -16'sh8000;
          2: return shortint'($urandom);
          default: return 16'sh0;
        endcase
      end
    endcase
  endfunction

  // Fills the rest of the current block, with basis writes mixed in.
  task automatic run_block(int style, bit keep_mirror);
    shortint   v;
    bit  [5:0] idx;
    int        r;
    int        c;
    do begin
      if ($urandom_range(99) < 6) begin
        v = ($urandom_range(1)) ? shortint'($urandom)
                                : shortint'($urandom_range(16383)) - 16'sd8192;
        if (keep_mirror) begin
          r = $urandom_range(7);
          c = $urandom_range(3);
          if (v == -16'sh8000) v = 16'sh0;
          send(KIND_BASIS, 6'(8*r+c), v, 16'sh0);
          send(KIND_BASIS, 6'(8*r+7-c), (r % 2) ? -v : v, 16'sh0);
        end else begin
          idx = 6'($urandom);
          send(KIND_BASIS, idx, v, 16'sh0);
        end
      end else begin
        send(KIND_SAMPLE, 6'($urandom), shortint'($urandom), pick_sample(style));
      end
    end while (fill != 0);
  endtask

  row_t directed[] = '{
    '{KIND_BASIS,  6'd0,  16'sh7FFF,  16'sh0},
    '{KIND_BASIS,  6'd63, -16'sh8000, 16'sh0},
    '{KIND_BASIS,  6'd36, 16'sh0,     16'sh0},
    '{KIND_BASIS,  6'd27, -16'sd1,    16'sh0},
    '{KIND_SAMPLE, 6'd0,  16'sh0,     16'sh7FFF},
    '{KIND_SAMPLE, 6'd63, 16'sh7FFF,  -16'sh8000},
    '{KIND_SAMPLE, 6'd0,  16'sh0,     16'sh0},
    '{KIND_SAMPLE, 6'd0,  16'sh0,     -16'sd1},
    '{KIND_SAMPLE, 6'd0,  16'sh0,     16'sd1},
    '{KIND_SAMPLE, 6'd0,  16'sh0,     16'sh5555},
    '{KIND_SAMPLE, 6'd0,  16'sh0,     -16'sh5556},
    '{KIND_SAMPLE, 6'd0,  16'sh0,     16'sh7FFF},
    '{KIND_SAMPLE, 6'd0,  16'sh0,     16'sh7FFF},
    '{KIND_BASIS,  6'd8,  16'sd1,     16'sh0},
    '{KIND_SAMPLE, 6'd0,  16'sh0,     -16'sh8000},
    '{KIND_SAMPLE, 6'd0,  16'sh0,     -16'sh8000},
    '{KIND_BASIS,  6'd9,  16'sh4000,  16'sh0}
  };

  initial begin
    logic [1:0] phase_mode[6] = '{MODE_EXACT, MODE_FAST, MODE_SYM, MODE_SYM, 2'd3, MODE_FAST};
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    errors    = 0;
    tx_quiet  = 1'b0;
    fill      = 0;
    cur_mode  = MODE_EXACT;
    for (int n = 0; n < 64; n++)
      basis_q14[n] = shortint'(int'(8192.0 * $cos((2.0 * (n % 8) + 1.0) * (n / 8)
                                                   * 3.14159265358979 / 16.0)));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_mode(MODE_EXACT);
    foreach (directed[i])
      send(directed[i].kind, directed[i].idx, directed[i].bval, directed[i].smp);
    run_block(2, 1'b0);
    for (int p = 1; p < 6; p++) begin
      set_mode(phase_mode[p]);
      if (p == 2) mirror_basis();
      if (p == 3) send(KIND_BASIS, 6'd13, basis_q14[13] + 16'sd1, 16'sh0);
      tx_quiet = (p == 2);
      run_block(p % 3, p == 2);
    end
    set_mode(MODE_EXACT);
    in_tvalid <= 1'b0;
    wait (coef_queue.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Receiver: random back-pressure, a quiet stretch and one long hold.
  initial begin
    out_tready = 1'b0;
    rx_held    = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (!rx_held && rx_count >= 140) begin
        rx_held = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      out_tready <= (rx_count >= 256 && rx_count < 320) || $urandom_range(99) >= 10;
    end
  end

  initial rx_count = 0;

  always @(posedge clk) begin
    coef_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (coef_queue.size() == 0) begin
        report_mismatch("unexpected transfer", int'($signed(out_tdata)), 0);
      end else begin
        want = coef_queue[0];
        coef_queue.delete(0);
        if ($signed(out_tdata) != want.coef)
          report_mismatch("coefficient", int'($signed(out_tdata)), int'(want.coef));
        if (out_tlast != want.last)
          report_mismatch("last flag", int'(out_tlast), int'(want.last));
        if (out_tuser != want.fault)
          report_mismatch("basis fault", int'(out_tuser), int'(want.fault));
      end
      rx_count++;
    end
  end

  // A transform plus the long receiver hold stays far below this limit.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 30000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
rtl/core/dct_pkg.sv
rtl/core/dct_ram.sv
rtl/core/dct_ctrl.sv
rtl/core/dct_dp.sv
rtl/core/dct8x8_forward_multimode.sv
tb/dct8x8_forward_multimode_tb.sv
